[src/spim_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master package
// Field widths and command codes shared by the SPI master files.
// ----------------------------------------------------------------------------
package spim_pkg;

   localparam int KIND_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int HALF_W   = 9;
   localparam int WAIT_W   = 9;
   localparam int BIT_IDX_W = 3;

   typedef logic [KIND_W-1:0] kind_type;

   localparam kind_type KIND_TICK     = 2'd0;
   localparam kind_type KIND_SELECT   = 2'd1;
   localparam kind_type KIND_TRANSFER = 2'd2;
   localparam kind_type KIND_DESELECT = 2'd3;

   localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 9'd5;

endpackage

[src/spim_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master channels
// Valid/ready channels for command beats and pin-state result beats.
// ----------------------------------------------------------------------------
interface spim_req_if;
   import spim_pkg::*;

   logic                valid;
   logic                ready;
   kind_type            kind;
   logic [BYTE_W-1:0]   tx_byte;
   logic                miso;

   modport source (output valid, kind, tx_byte, miso, input ready);
   modport sink   (input valid, kind, tx_byte, miso, output ready);
endinterface

interface spim_rsp_if;
   import spim_pkg::*;

   logic                valid;
   logic                ready;
   logic                cs_n;
   logic                sclk;
   logic                mosi;
   logic [BYTE_W-1:0]   rx_byte;
   logic                rx_valid;
   logic                busy_res;
   logic                rejected;

   modport source (output valid, cs_n, sclk, mosi, rx_byte, rx_valid, busy_res, rejected,
                   input ready);
   modport sink   (input valid, cs_n, sclk, mosi, rx_byte, rx_valid, busy_res, rejected,
                   output ready);
endinterface

[src/spi_master_lsb_first_timed_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pin-timed SPI master, clock idle high, LSB first
// Each request beat is a 1 us tick or a select/transfer/deselect command;
// each one yields one response beat with the line levels after it.
// ----------------------------------------------------------------------------
// Takes one request beat per clock and returns its response in the next cycle
// from a single output register; the request side stalls only while that
// register holds a beat the sink has not taken. The pin sequencer (phase,
// wait counter, bit index, shift registers) advances only on tick beats;
// commands arriving while a sequence runs are dropped and flagged rejected.
// half_period is read whenever a clock-phase wait is loaded, so a write between
// commands takes effect at the next such wait; a value of 0 behaves as 1.
module spi_master_lsb_first_timed_unit #(
   parameter int ATTN_DELAY       = 20,
   parameter int PRE_SELECT_DELAY = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   spim_req_if.sink                     req_ch,
   spim_rsp_if.source                   rsp_ch,
   input  logic                         csr_we,
   input  logic [spim_pkg::HALF_W-1:0]  csr_wdata
);
   import spim_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE, PH_PRE, PH_ATTN, PH_DESEL, PH_SETUP, PH_LOW, PH_SETTLE, PH_HOLD
   } phase_type;

   localparam logic [WAIT_W-1:0] ATTN_WAIT = WAIT_W'(ATTN_DELAY);
   localparam logic [WAIT_W-1:0] PRE_WAIT  = WAIT_W'(PRE_SELECT_DELAY);

   phase_type              phase_ff, phase_in;
   logic [WAIT_W-1:0]      wait_ff, wait_in;
   logic [BIT_IDX_W-1:0]   bit_ff, bit_in;
   logic [BYTE_W-1:0]      send_ff, send_in;
   logic [BYTE_W-1:0]      recv_ff, recv_in;
   logic                   sel_ff, sel_in;
   logic                   clk_lvl_ff, clk_lvl_in;
   logic                   data_ff, data_in;
   logic [HALF_W-1:0]      half_ff;

   logic                   rsp_valid_ff;
   logic                   rx_valid_ff, rx_valid_in;
   logic [BYTE_W-1:0]      rx_byte_ff, rx_byte_in;
   logic                   rejected_ff, rejected_in;

   logic                   accept;
   logic [WAIT_W-1:0]      eff_half;
   logic [WAIT_W-1:0]      wait_dec;
   logic [BYTE_W-1:0]      recv_cur;
   logic                   finish;
   logic [BIT_IDX_W-1:0]   bit_next;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign eff_half = (half_ff == '0) ? WAIT_W'(1) : WAIT_W'(half_ff);
   assign wait_dec = (wait_ff != '0) ? wait_ff - WAIT_W'(1) : '0;
   assign bit_next = bit_ff + BIT_IDX_W'(1);

   always_comb begin
      phase_in    = phase_ff;
      wait_in     = wait_ff;
      bit_in      = bit_ff;
      send_in     = send_ff;
      recv_in     = recv_ff;
      sel_in      = sel_ff;
      clk_lvl_in  = clk_lvl_ff;
      data_in     = data_ff;
      rx_valid_in = 1'b0;
      rx_byte_in  = '0;
      rejected_in = 1'b0;
      recv_cur    = recv_ff;
      finish      = 1'b0;

      if (req_ch.kind != KIND_TICK) begin
         if (phase_ff != PH_IDLE) begin
            rejected_in = 1'b1;
         end else begin
            case (req_ch.kind)
               KIND_SELECT: begin
                  data_in    = 1'b1;
                  clk_lvl_in = 1'b1;
                  phase_in   = PH_PRE;
                  wait_in    = PRE_WAIT;
               end
               KIND_TRANSFER: begin
                  send_in  = req_ch.tx_byte;
                  recv_in  = '0;
                  bit_in   = '0;
                  data_in  = req_ch.tx_byte[0];
                  phase_in = PH_SETUP;
                  wait_in  = eff_half;
               end
               KIND_DESELECT: begin
                  phase_in = PH_DESEL;
                  wait_in  = ATTN_WAIT;
               end
               default: begin
               end
            endcase
         end
      end else if (phase_ff != PH_IDLE) begin
         wait_in = wait_dec;
         if (wait_dec == '0) begin
            case (phase_ff)
               PH_PRE: begin
                  sel_in   = 1'b0;
                  phase_in = PH_ATTN;
                  wait_in  = ATTN_WAIT;
               end
               PH_ATTN: begin
                  phase_in = PH_IDLE;
               end
               PH_DESEL: begin
                  sel_in     = 1'b1;
                  clk_lvl_in = 1'b1;
                  data_in    = 1'b1;
                  phase_in   = PH_IDLE;
               end
               PH_SETUP: begin
                  clk_lvl_in = 1'b0;
                  phase_in   = PH_LOW;
                  wait_in    = eff_half;
               end
               PH_LOW: begin
                  clk_lvl_in = 1'b1;
                  phase_in   = PH_SETTLE;
                  wait_in    = WAIT_W'(1);
               end
               PH_SETTLE: begin
                  recv_cur[bit_ff] = recv_ff[bit_ff] | req_ch.miso;
                  recv_in  = recv_cur;
                  phase_in = PH_HOLD;
                  wait_in  = eff_half - WAIT_W'(1);
                  // half period of one: no hold time, go straight to next bit
                  finish   = (eff_half == WAIT_W'(1));
               end
               PH_HOLD: begin
                  finish = 1'b1;
               end
               default: begin
               end
            endcase

            if (finish) begin
               if (bit_ff == '1) begin
                  phase_in    = PH_IDLE;
                  wait_in     = '0;
                  rx_valid_in = 1'b1;
                  rx_byte_in  = recv_cur;
               end else begin
                  bit_in   = bit_next;
                  data_in  = send_ff[bit_next];
                  phase_in = PH_SETUP;
                  wait_in  = eff_half;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         wait_ff      <= '0;
         bit_ff       <= '0;
         send_ff      <= '0;
         recv_ff      <= '0;
         sel_ff       <= 1'b1;
         clk_lvl_ff   <= 1'b1;
         data_ff      <= 1'b1;
         half_ff      <= HALF_PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            half_ff <= csr_wdata;
         end
         if (accept) begin
            phase_ff    <= phase_in;
            wait_ff     <= wait_in;
            bit_ff      <= bit_in;
            send_ff     <= send_in;
            recv_ff     <= recv_in;
            sel_ff      <= sel_in;
            clk_lvl_ff  <= clk_lvl_in;
            data_ff     <= data_in;
            rx_valid_ff <= rx_valid_in;
            rx_byte_ff  <= rx_byte_in;
            rejected_ff <= rejected_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // pin levels come straight from the sequencer state of the last beat
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.cs_n     = sel_ff;
   assign rsp_ch.sclk     = clk_lvl_ff;
   assign rsp_ch.mosi     = data_ff;
   assign rsp_ch.rx_byte  = rx_byte_ff;
   assign rsp_ch.rx_valid = rx_valid_ff;
   assign rsp_ch.busy_res = (phase_ff != PH_IDLE);
   assign rsp_ch.rejected = rejected_ff;

endmodule

[src/spim_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master port checker
// Watches the response channel of the SPI master and flags bad beats.
// ----------------------------------------------------------------------------
module spim_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [spim_pkg::KIND_W-1:0]  req_kind,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [spim_pkg::BYTE_W-1:0]  rx_byte,
   input logic                         rx_valid,
   input logic                         busy_res,
   input logic                         rejected
);
   import spim_pkg::*;

   // a stalled result beat keeps its received byte
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rx_byte) && $stable(rx_valid))
      else $error("response beat changed while stalled");

   // a completed byte leaves the master idle
   a_rx_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rx_valid |-> !busy_res)
      else $error("rx_valid while still busy");

   // only a running sequence can reject a command
   a_rej_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rejected |-> busy_res)
      else $error("rejected while idle");

   // a tick beat is never rejected
   a_tick_no_rej: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_TICK) |=> rsp_valid && !rejected)
      else $error("tick beat flagged rejected");

   // received byte reads zero outside the completing beat
   a_rx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rx_valid |-> (rx_byte == '0))
      else $error("rx_byte nonzero without rx_valid");

endmodule

bind spi_master_lsb_first_timed_unit spim_checker u_spim_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_kind  (req_ch.kind),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rx_byte   (rsp_ch.rx_byte),
   .rx_valid  (rsp_ch.rx_valid),
   .busy_res  (rsp_ch.busy_res),
   .rejected  (rsp_ch.rejected)
);

[bench/spi_master_lsb_first_timed_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master pin sequencer testbench
// Feeds tick and command beats through the request channel and checks every
// response beat, field by field, against a cycle-free copy of the pin
// sequence. A short directed table comes first, then random sessions under
// several half-period settings, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module spi_master_lsb_first_timed_unit_test;
   import spim_pkg::*;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int RANDOM_BEATS   = 800;
   localparam int ATTN_TICKS     = 20;
   localparam int PRE_SEL_TICKS  = 2;
   localparam int SQUEEZE_AT     = 600;
   localparam int SQUEEZE_CYCLES = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_LIMIT    = 20_000;
   localparam int MAX_REPORTS    = 50;
   localparam int PLAN_LEN       = 8;
   localparam int DIR_ROWS       = 18;
   localparam logic [HALF_W-1:0] HALF_MAX = '1;

   typedef enum logic [2:0] {
      SEQ_IDLE, SEQ_PRE, SEQ_ATTN, SEQ_DESEL, SEQ_SETUP, SEQ_LOW, SEQ_SETTLE, SEQ_HOLD
   } seq_state_type;

   typedef enum logic [1:0] {MISO_LOW, MISO_HIGH, MISO_RAND} miso_src_type;

   typedef struct packed {
      logic              cs_n;
      logic              sclk;
      logic              mosi;
      logic [BYTE_W-1:0] rx_byte;
      logic              rx_valid;
      logic              busy;
      logic              rejected;
   } pin_beat_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] tx;
      miso_src_type      miso;
      logic [7:0]        reps;    // 0: keep ticking until the sequencer is idle
      logic              typed;
      pin_beat_type      want;
   } dir_row_type;

   localparam pin_beat_type PINS_IDLE   = '{1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0};
   localparam pin_beat_type PINS_BUSY   = '{1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0};
   localparam pin_beat_type PINS_REFUSE = '{1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1};
   localparam pin_beat_type PINS_SEL_HI = '{1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0};
   localparam pin_beat_type PINS_SEL_LO = '{1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0};

   // run with half period 0, so every bit takes three ticks
   dir_row_type dir_steps [DIR_ROWS] = '{
      '{KIND_TICK,     8'h00, MISO_HIGH, 8'd1, 1'b1, PINS_IDLE},
      '{KIND_TICK,     8'hFF, MISO_LOW,  8'd1, 1'b1, PINS_IDLE},
      '{KIND_DESELECT, 8'h00, MISO_LOW,  8'd1, 1'b1, PINS_BUSY},
      '{KIND_SELECT,   8'h00, MISO_LOW,  8'd1, 1'b1, PINS_REFUSE},
      '{KIND_TICK,     8'h00, MISO_LOW,  8'd0, 1'b0, PINS_IDLE},
      '{KIND_SELECT,   8'hFF, MISO_HIGH, 8'd1, 1'b1, PINS_BUSY},
      '{KIND_TRANSFER, 8'hFF, MISO_HIGH, 8'd1, 1'b1, PINS_REFUSE},
      '{KIND_DESELECT, 8'h00, MISO_LOW,  8'd1, 1'b1, PINS_REFUSE},
      '{KIND_TICK,     8'h00, MISO_HIGH, 8'd0, 1'b0, PINS_IDLE},
      '{KIND_TRANSFER, 8'hFF, MISO_LOW,  8'd1, 1'b1, PINS_SEL_HI},
      '{KIND_TICK,     8'h00, MISO_HIGH, 8'd0, 1'b0, PINS_IDLE},
      '{KIND_TRANSFER, 8'h00, MISO_HIGH, 8'd1, 1'b1, PINS_SEL_LO},
      '{KIND_TICK,     8'hFF, MISO_LOW,  8'd0, 1'b0, PINS_IDLE},
      '{KIND_TRANSFER, 8'hA5, MISO_LOW,  8'd1, 1'b0, PINS_IDLE},
      '{KIND_TICK,     8'h00, MISO_RAND, 8'd0, 1'b0, PINS_IDLE},
      '{KIND_DESELECT, 8'h00, MISO_LOW,  8'd1, 1'b0, PINS_IDLE},
      '{KIND_TICK,     8'h00, MISO_LOW,  8'd0, 1'b0, PINS_IDLE},
      '{KIND_TICK,     8'h00, MISO_HIGH, 8'd1, 1'b1, PINS_IDLE}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_we;
   logic [HALF_W-1:0] csr_wdata;

   spim_req_if req_ch ();
   spim_rsp_if rsp_ch ();

   spi_master_lsb_first_timed_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // predicted sequencer state
   seq_state_type       seq_state;
   logic [WAIT_W-1:0]   wait_left;
   logic [2:0]          bit_pos;
   logic [BYTE_W-1:0]   tx_shift;
   logic [BYTE_W-1:0]   rx_shift;
   logic                sel_n;
   logic                clk_lvl;
   logic                dat_lvl;
   logic [HALF_W-1:0]   half_cfg;

   pin_beat_type pin_beats_due [$];

   int  err_count      = 0;
   int  beats_checked  = 0;
   int  bytes_seen     = 0;
   int  refusals_seen  = 0;
   int  live_beats     = 0;
   int  settings_used  = 0;
   int  cycle_count    = 0;
   int  burst_left     = 0;
   bit  steady_sender  = 1'b0;

   function automatic logic [WAIT_W-1:0] half_ticks();
      return (half_cfg == '0) ? WAIT_W'(1) : WAIT_W'(half_cfg);
   endfunction

   function automatic void start_bit();
      dat_lvl   = tx_shift[bit_pos];
      seq_state = SEQ_SETUP;
      wait_left = half_ticks();
   endfunction

   // true once bit 7 has been sampled
   function automatic logic end_bit();
      if (bit_pos == 3'd7) begin
         seq_state = SEQ_IDLE;
         wait_left = '0;
         return 1'b1;
      end
      bit_pos = bit_pos + 3'd1;
      start_bit();
      return 1'b0;
   endfunction

   function automatic pin_beat_type spi_pins_step(kind_type kind, logic [BYTE_W-1:0] tx,
                                                  logic miso);
      pin_beat_type r;
      logic         done;
      r    = '0;
      done = 1'b0;
      if (kind != KIND_TICK) begin
         if (seq_state != SEQ_IDLE) begin
            r.rejected = 1'b1;
         end else begin
            case (kind)
               KIND_SELECT: begin
                  dat_lvl   = 1'b1;
                  clk_lvl   = 1'b1;
                  seq_state = SEQ_PRE;
                  wait_left = WAIT_W'(PRE_SEL_TICKS);
               end
               KIND_TRANSFER: begin
                  tx_shift = tx;
                  rx_shift = '0;
                  bit_pos  = '0;
                  start_bit();
               end
               default: begin
                  seq_state = SEQ_DESEL;
                  wait_left = WAIT_W'(ATTN_TICKS);
               end
            endcase
         end
      end else if (seq_state != SEQ_IDLE) begin
         if (wait_left != '0) wait_left = wait_left - WAIT_W'(1);
         if (wait_left == '0) begin
            case (seq_state)
               SEQ_PRE: begin
                  sel_n     = 1'b0;
                  seq_state = SEQ_ATTN;
                  wait_left = WAIT_W'(ATTN_TICKS);
               end
               SEQ_ATTN: seq_state = SEQ_IDLE;
               SEQ_DESEL: begin
                  sel_n     = 1'b1;
                  clk_lvl   = 1'b1;
                  dat_lvl   = 1'b1;
                  seq_state = SEQ_IDLE;
               end
               SEQ_SETUP: begin
                  clk_lvl   = 1'b0;
                  seq_state = SEQ_LOW;
                  wait_left = half_ticks();
               end
               SEQ_LOW: begin
                  clk_lvl   = 1'b1;
                  seq_state = SEQ_SETTLE;
                  wait_left = WAIT_W'(1);
               end
               SEQ_SETTLE: begin
                  if (miso) rx_shift[bit_pos] = 1'b1;
                  seq_state = SEQ_HOLD;
                  wait_left = half_ticks() - WAIT_W'(1);
                  // half period of one: no hold wait, next bit at once
                  if (wait_left == '0) done = end_bit();
               end
               default: done = end_bit();
            endcase
         end
      end
      r.cs_n     = sel_n;
      r.sclk     = clk_lvl;
      r.mosi     = dat_lvl;
      r.rx_valid = done;
      r.rx_byte  = done ? rx_shift : '0;
      r.busy     = (seq_state != SEQ_IDLE);
      return r;
   endfunction

   task automatic note_mismatch(string what, int got, int want);
      err_count++;
      if (err_count <= MAX_REPORTS)
         $display("MISMATCH at beat %0d, %s: got %0h, want %0h", beats_checked, what, got, want);
   endtask

   // one request beat, with burst/gap shaping on the sender side
   task automatic push_beat(kind_type kind, logic [BYTE_W-1:0] tx, logic miso,
                            bit typed = 1'b0, pin_beat_type want = '0);
      int           gap;
      pin_beat_type due;
      if (burst_left == 0) begin
         burst_left = steady_sender ? 64 : $urandom_range(1, 16);
         gap        = steady_sender ? 0 : $urandom_range(0, 8);
         if (gap != 0) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.kind    <= kind;
      req_ch.tx_byte <= tx;
      req_ch.miso    <= miso;
      do @(posedge clock); while (!req_ch.ready);
      if (kind != KIND_TICK || seq_state != SEQ_IDLE) live_beats++;
      due = spi_pins_step(kind, tx, miso);
      pin_beats_due.push_back(typed ? want : due);
   endtask

   // ticks until the sequencer is idle, with the odd refused command mixed in
   task automatic tick_until_idle();
      while (seq_state != SEQ_IDLE) begin
         if ($urandom_range(0, 19) == 0)
            push_beat(kind_type'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
         else
            push_beat(KIND_TICK, 8'($urandom), 1'($urandom));
      end
   endtask

   task automatic run_spi_session(int max_bytes);
      int                n;
      logic [BYTE_W-1:0] b;
      if ($urandom_range(0, 9) == 0) begin
         // broken session: commands in any order
         repeat ($urandom_range(1, 4))
            push_beat(kind_type'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
         tick_until_idle();
      end else begin
         push_beat(KIND_SELECT, 8'($urandom), 1'($urandom));
         tick_until_idle();
         n = $urandom_range(1, max_bytes);
         repeat (n) begin
            case ($urandom_range(0, 7))
               0:       b = 8'h00;
               1:       b = 8'hFF;
               default: b = 8'($urandom);
            endcase
            push_beat(KIND_TRANSFER, b, 1'($urandom));
            tick_until_idle();
         end
         push_beat(KIND_DESELECT, 8'($urandom), 1'($urandom));
         tick_until_idle();
      end
      repeat ($urandom_range(0, 2)) push_beat(KIND_TICK, 8'($urandom), 1'($urandom));
   endtask

   task automatic quiet_sender();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      burst_left = 0;
   endtask

   task automatic load_half_period(logic [HALF_W-1:0] value);
      quiet_sender();
      while (pin_beats_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      half_cfg = value;
      settings_used++;
   endtask

   // response checker
   always @(posedge clock) begin
      pin_beat_type got;
      pin_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.cs_n, rsp_ch.sclk, rsp_ch.mosi, rsp_ch.rx_byte,
                rsp_ch.rx_valid, rsp_ch.busy_res, rsp_ch.rejected};
         beats_checked++;
         if (got.rx_valid === 1'b1) bytes_seen++;
         if (got.rejected === 1'b1) refusals_seen++;
         if (pin_beats_due.size() == 0) begin
            note_mismatch("beat with nothing due", got, 0);
         end else begin
            want = pin_beats_due.pop_front();
            if (got.cs_n !== want.cs_n)         note_mismatch("cs_n", got.cs_n, want.cs_n);
            if (got.sclk !== want.sclk)         note_mismatch("sclk", got.sclk, want.sclk);
            if (got.mosi !== want.mosi)         note_mismatch("mosi", got.mosi, want.mosi);
            if (got.rx_byte !== want.rx_byte)   note_mismatch("rx_byte", got.rx_byte, want.rx_byte);
            if (got.rx_valid !== want.rx_valid) note_mismatch("rx_valid", got.rx_valid, want.rx_valid);
            if (got.busy !== want.busy)         note_mismatch("busy_res", got.busy, want.busy);
            if (got.rejected !== want.rejected) note_mismatch("rejected", got.rejected, want.rejected);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("spi_master_lsb_first_timed_unit_test: errors");
         $finish;
      end
   end

   // receiver: stall pattern changes every so often, plus one long hold-off
   initial begin
      int mode;
      int mode_left;
      int squeeze_left;
      int rx_cycle;
      bit squeezed;
      mode         = 0;
      mode_left    = 0;
      squeeze_left = 0;
      rx_cycle     = 0;
      squeezed     = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         if (!squeezed && beats_checked >= SQUEEZE_AT) begin
            squeezed     = 1'b1;
            squeeze_left = SQUEEZE_CYCLES;
         end
         if (squeeze_left > 0) begin
            squeeze_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
               2:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ch.ready <= (rx_cycle % 3 != 0);
            endcase
         end
      end
   end

   // stimulus
   initial begin
      logic [HALF_W-1:0] half_plan [PLAN_LEN];
      logic              m;
      int                i;
      int                n;
      int                p;
      int                waited;

      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.kind    = KIND_TICK;
      req_ch.tx_byte = '0;
      req_ch.miso    = 1'b0;

      seq_state = SEQ_IDLE;
      wait_left = '0;
      bit_pos   = '0;
      tx_shift  = '0;
      rx_shift  = '0;
      sel_n     = 1'b1;
      clk_lvl   = 1'b1;
      dat_lvl   = 1'b1;
      half_cfg  = HALF_PERIOD_RESET;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, zero half period acts as one
      load_half_period('0);
      for (i = 0; i < DIR_ROWS; i++) begin
         n = 0;
         do begin
            case (dir_steps[i].miso)
               MISO_RAND: m = 1'($urandom_range(0, 1));
               MISO_HIGH: m = 1'b1;
               default:   m = 1'b0;
            endcase
            push_beat(dir_steps[i].kind, dir_steps[i].tx, m, dir_steps[i].typed,
                      dir_steps[i].want);
            n++;
         end while ((dir_steps[i].reps == 0) ? (seq_state != SEQ_IDLE)
                                             : (n < dir_steps[i].reps));
      end

      // random sessions across half-period settings
      half_plan = '{HALF_PERIOD_RESET, 9'd1, 9'd0, 9'd2, 9'd3, 9'd7,
                    HALF_W'($urandom_range(1, 12)), 9'd4};
      live_beats = 0;
      for (p = 0; p < PLAN_LEN; p++) begin
         load_half_period(half_plan[p]);
         steady_sender = ($urandom_range(0, 3) == 0);
         while (live_beats < (RANDOM_BEATS / PLAN_LEN) * (p + 1)) run_spi_session(3);
      end

      // widest setting loads the first wait of a byte, then the period drops
      // to one while that byte is still running
      load_half_period(HALF_MAX);
      steady_sender = 1'b1;
      push_beat(KIND_TRANSFER, 8'($urandom), 1'($urandom));
      load_half_period(9'd1);
      tick_until_idle();
      steady_sender = 1'b0;
      run_spi_session(2);

      quiet_sender();
      waited = 0;
      while (pin_beats_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pin_beats_due.size() != 0)
         note_mismatch("beats never returned", pin_beats_due.size(), 0);

      $display("covered %0d response beats: %0d bytes received, %0d commands refused while busy",
               beats_checked, bytes_seen, refusals_seen);
      $display("%0d half-period writes, from zero up to the 9-bit maximum", settings_used);
      if (err_count == 0) begin
         $display("spi_master_lsb_first_timed_unit_test: clean");
      end else begin
         $display("spi_master_lsb_first_timed_unit_test: errors");
      end
      $finish;
   end

endmodule

[sim.f]
src/spim_pkg.sv
src/spim_if.sv
src/spi_master_lsb_first_timed_unit.sv
src/spim_checker.sv
bench/spi_master_lsb_first_timed_unit_test.sv
